/* rtl/ubd_pkg.sv */
// ----------------------------------------------------------------------------
// ubd_pkg
// Shared widths, constants and types of the UART baud divisor calculator.
// ----------------------------------------------------------------------------
package ubd_pkg;

  localparam int CLK_W   = 28;
  localparam int BAUD_W  = 24;
  localparam int PORT_W  = 3;
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Dividend is 25 * clock, divisor is 2 or 4 times the baud rate.
  localparam int DVD_W   = CLK_W + 5;
  localparam int DVS_W   = BAUD_W + 2;
  localparam int QUO_W   = DVD_W;

  // Restoring divider: quotient bits resolved per pipeline stage.
  localparam int BPS        = 3;
  localparam int DIV_STAGES = QUO_W / BPS;

  // Quotient / 100 is computed as (quotient >> 2) / 25 by reciprocal.
  localparam int                 RQ_W      = QUO_W - 2;
  localparam int                 RECIP_W   = 32;
  localparam logic [RECIP_W-1:0] RECIP_25  = 32'd2748779070;
  localparam int                 RECIP_SH  = 36;
  localparam int                 PROD_W    = RQ_W + RECIP_W;
  localparam int                 MANT_W    = PROD_W - RECIP_SH;
  localparam int                 REM_W     = 7;
  localparam logic [QUO_W-1:0]   SCALE_DEN = 33'd100;

  // Fraction: (rem * S + 50) / 100 through a reciprocal of 100.
  localparam int                 FV_W       = 11;
  localparam logic [FV_W-1:0]    ROUND_HALF = 11'd50;
  localparam int                 FPROD_W    = 2 * FV_W;
  localparam logic [FPROD_W-1:0] FRAC_RECIP = 22'd1311;
  localparam int                 FRAC_SH    = 17;
  localparam int                 FRAC_W     = 4;

  localparam logic [CLK_W-1:0]   CLK_RESET  = 28'd16000000;

  localparam logic [PORT_W-1:0]    PORT_BUS2_LO = 3'd0;
  localparam logic [PORT_W-1:0]    PORT_BUS2_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS1_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS2_IDX = 2'd1;

  typedef struct packed {
    logic over8;
    logic err;
  } side_t;

endpackage

/* rtl/uart_baud_divisor_calc_top.sv */
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_top
// Forms the UART baud-rate register word from port, baud rate and mode.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    in_port_index, in_baud_rate,
//                                 in_oversample_by_8
//   out      out_valid/out_ready  out_divisor_word, out_divide_error
//   cfg      cfg_we               cfg_index, cfg_wdata
//
// One beat is accepted per cycle while in_ready is high; a result passes
// through fifteen registers: one operand stage, eleven divider stages of
// three quotient bits each, a reciprocal multiply, a remainder stage and
// the output register.
// Synchronous reset empties every stage and loads both clocks with 16 MHz.
// A stalled output holds its beat while empty stages upstream keep filling.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ubd_pkg::PORT_W-1:0]    in_port_index,
  input  logic [ubd_pkg::BAUD_W-1:0]    in_baud_rate,
  input  logic                          in_oversample_by_8,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ubd_pkg::WORD_W-1:0]    out_divisor_word,
  output logic                          out_divide_error,
  input  logic                          cfg_we,
  input  logic [ubd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ubd_pkg::CLK_W-1:0]     cfg_wdata
);

  logic [ubd_pkg::CLK_W-1:0] bus1_r;
  logic [ubd_pkg::CLK_W-1:0] bus2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus1_r <= ubd_pkg::CLK_RESET;
      bus2_r <= ubd_pkg::CLK_RESET;
    end else if (cfg_we) begin
      if (cfg_index == ubd_pkg::CFG_BUS1_IDX) begin
        bus1_r <= cfg_wdata;
      end
      if (cfg_index == ubd_pkg::CFG_BUS2_IDX) begin
        bus2_r <= cfg_wdata;
      end
    end
  end

  // Operand stage.
  logic                        s0_vld_r;
  logic [ubd_pkg::DVD_W-1:0]   s0_dvd_r;
  logic [ubd_pkg::DVS_W-1:0]   s0_dvs_r;
  ubd_pkg::side_t              s0_side_r;
  logic                        s0_adv;
  logic                        div_in_ready;
  logic [ubd_pkg::CLK_W-1:0]   clk_sel;
  logic [ubd_pkg::DVD_W-1:0]   clk_ext;
  logic [ubd_pkg::DVD_W-1:0]   s0_dvd_nxt;
  logic [ubd_pkg::DVS_W-1:0]   s0_dvs_nxt;
  ubd_pkg::side_t              s0_side_nxt;

  always_comb begin
    if (in_port_index == ubd_pkg::PORT_BUS2_LO || in_port_index == ubd_pkg::PORT_BUS2_HI) begin
      clk_sel = bus2_r;
    end else begin
      clk_sel = bus1_r;
    end
    clk_ext    = ubd_pkg::DVD_W'(clk_sel);
    s0_dvd_nxt = (clk_ext << 4) + (clk_ext << 3) + clk_ext;
    if (in_oversample_by_8) begin
      s0_dvs_nxt = {1'b0, in_baud_rate, 1'b0};
    end else begin
      s0_dvs_nxt = {in_baud_rate, 2'b00};
    end
    s0_side_nxt.over8 = in_oversample_by_8;
    s0_side_nxt.err   = (in_baud_rate == '0);
  end

  assign s0_adv   = !s0_vld_r || div_in_ready;
  assign in_ready = s0_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s0_dvd_r  <= s0_dvd_nxt;
      s0_dvs_r  <= s0_dvs_nxt;
      s0_side_r <= s0_side_nxt;
    end
  end

  // Divider.
  logic                      div_out_valid;
  logic                      p1_adv;
  logic [ubd_pkg::QUO_W-1:0] div_quo;
  ubd_pkg::side_t            div_side;

  ubd_div_pipe u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (s0_vld_r),
    .in_ready     (div_in_ready),
    .in_dividend  (s0_dvd_r),
    .in_divisor   (s0_dvs_r),
    .in_side      (s0_side_r),
    .out_valid    (div_out_valid),
    .out_ready    (p1_adv),
    .out_quotient (div_quo),
    .out_side     (div_side)
  );

  // Reciprocal multiply for the division by 100.
  logic                       p1_vld_r;
  logic [ubd_pkg::PROD_W-1:0] p1_prod_r;
  logic [ubd_pkg::QUO_W-1:0]  p1_quo_r;
  ubd_pkg::side_t             p1_side_r;
  logic [ubd_pkg::PROD_W-1:0] p1_prod_nxt;
  logic                       p2_adv;

  assign p1_adv      = !p1_vld_r || p2_adv;
  assign p1_prod_nxt = ubd_pkg::PROD_W'(div_quo[ubd_pkg::QUO_W-1:2])
                     * ubd_pkg::PROD_W'(ubd_pkg::RECIP_25);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (p1_adv) begin
      p1_vld_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p1_prod_r <= p1_prod_nxt;
      p1_quo_r  <= div_quo;
      p1_side_r <= div_side;
    end
  end

  // Mantissa and remainder.
  logic                       p2_vld_r;
  logic [ubd_pkg::MANT_W-1:0] p2_mant_r;
  logic [ubd_pkg::REM_W-1:0]  p2_rem_r;
  ubd_pkg::side_t             p2_side_r;
  logic [ubd_pkg::MANT_W-1:0] p2_mant_nxt;
  logic [ubd_pkg::QUO_W-1:0]  p2_rem_full;
  logic                       p3_adv;

  assign p2_adv      = !p2_vld_r || p3_adv;
  assign p2_mant_nxt = p1_prod_r[ubd_pkg::RECIP_SH +: ubd_pkg::MANT_W];
  assign p2_rem_full = p1_quo_r - ubd_pkg::QUO_W'(p2_mant_nxt) * ubd_pkg::SCALE_DEN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (p2_adv) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_adv) begin
      p2_mant_r <= p2_mant_nxt;
      p2_rem_r  <= p2_rem_full[ubd_pkg::REM_W-1:0];
      p2_side_r <= p1_side_r;
    end
  end

  // Fraction and output register.
  logic                        out_vld_r;
  logic [ubd_pkg::WORD_W-1:0]  out_word_r;
  logic                        out_err_r;
  logic [ubd_pkg::FV_W-1:0]    frac_val;
  logic [ubd_pkg::FPROD_W-1:0] frac_prod;
  logic [ubd_pkg::FRAC_W:0]    frac_q;
  logic [ubd_pkg::FRAC_W-1:0]  frac_bits;
  logic [ubd_pkg::WORD_W-1:0]  word_nxt;

  assign p3_adv = !out_vld_r || out_ready;

  always_comb begin
    if (p2_side_r.over8) begin
      frac_val = ubd_pkg::FV_W'({p2_rem_r, 3'b000}) + ubd_pkg::ROUND_HALF;
    end else begin
      frac_val = ubd_pkg::FV_W'({p2_rem_r, 4'b0000}) + ubd_pkg::ROUND_HALF;
    end
    frac_prod = ubd_pkg::FPROD_W'(frac_val) * ubd_pkg::FRAC_RECIP;
    frac_q    = frac_prod[ubd_pkg::FRAC_SH +: (ubd_pkg::FRAC_W + 1)];
    if (p2_side_r.over8) begin
      frac_bits = {1'b0, frac_q[ubd_pkg::FRAC_W-2:0]};
    end else begin
      frac_bits = frac_q[ubd_pkg::FRAC_W-1:0];
    end
    if (p2_side_r.err) begin
      word_nxt = '0;
    end else begin
      word_nxt = ubd_pkg::WORD_W'({p2_mant_r, frac_bits});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (p3_adv) begin
      out_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_adv) begin
      out_word_r <= word_nxt;
      out_err_r  <= p2_side_r.err;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_divisor_word = out_word_r;
  assign out_divide_error = out_err_r;

  // Checks.
  a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s0_vld_r)
    else $error("input stage refused a beat while empty");

  a_mid_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p2_vld_r && !p3_adv) |=> (p2_vld_r && $stable(p2_mant_r) && $stable(p2_rem_r)))
    else $error("remainder stage changed while stalled");

  a_error_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_error) |-> (out_divisor_word == '0))
    else $error("zero baud rate gave a nonzero divisor word");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s0_vld_r))
    else $error("pipeline not empty after reset");

endmodule

/* rtl/ubd_div_pipe.sv */
// ----------------------------------------------------------------------------
// ubd_div_pipe
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
module ubd_div_pipe (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ubd_pkg::DVD_W-1:0] in_dividend,
  input  logic [ubd_pkg::DVS_W-1:0] in_divisor,
  input  ubd_pkg::side_t            in_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ubd_pkg::QUO_W-1:0] out_quotient,
  output ubd_pkg::side_t            out_side
);

  localparam int NS = ubd_pkg::DIV_STAGES;

  logic                      vld_r  [NS];
  logic [ubd_pkg::DVS_W-1:0] rem_r  [NS];
  logic [ubd_pkg::QUO_W-1:0] dq_r   [NS];
  logic [ubd_pkg::DVS_W-1:0] dvs_r  [NS];
  ubd_pkg::side_t            side_r [NS];

  logic                      adv    [NS];
  logic [ubd_pkg::DVS_W-1:0] rem_nxt [NS];
  logic [ubd_pkg::QUO_W-1:0] dq_nxt  [NS];
  logic [ubd_pkg::DVS_W-1:0] dvs_nxt [NS];
  ubd_pkg::side_t            side_nxt [NS];
  logic                      vld_nxt [NS];

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
  end

  always_comb begin
    logic [ubd_pkg::DVS_W-1:0] rem;
    logic [ubd_pkg::QUO_W-1:0] dq;
    logic [ubd_pkg::DVS_W:0]   trial;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rem          = '0;
        dq           = in_dividend;
        dvs_nxt[s]   = in_divisor;
        side_nxt[s]  = in_side;
        vld_nxt[s]   = in_valid;
      end else begin
        rem          = rem_r[s-1];
        dq           = dq_r[s-1];
        dvs_nxt[s]   = dvs_r[s-1];
        side_nxt[s]  = side_r[s-1];
        vld_nxt[s]   = vld_r[s-1];
      end
      for (int b = 0; b < ubd_pkg::BPS; b++) begin
        trial = {rem, dq[ubd_pkg::QUO_W-1]};
        dq    = {dq[ubd_pkg::QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs_nxt[s]}) begin
          trial = trial - {1'b0, dvs_nxt[s]};
          dq[0] = 1'b1;
        end
        rem = trial[ubd_pkg::DVS_W-1:0];
      end
      rem_nxt[s] = rem;
      dq_nxt[s]  = dq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (adv[s]) begin
          vld_r[s] <= vld_nxt[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (adv[s]) begin
        rem_r[s]  <= rem_nxt[s];
        dq_r[s]   <= dq_nxt[s];
        dvs_r[s]  <= dvs_nxt[s];
        side_r[s] <= side_nxt[s];
      end
    end
  end

  assign in_ready     = adv[0];
  assign out_valid    = vld_r[NS-1];
  assign out_quotient = dq_r[NS-1];
  assign out_side     = side_r[NS-1];

endmodule
